>>> rtl/fsh_pkg.sv
// fsh_pkg: types, constant tables and the single-round permutation function
// for the feed-forward sponge hash. No dependencies.
`timescale 1ns / 1ps

package fsh_pkg;

    typedef logic [63:0] word_t;
    typedef word_t [31:0] state_t;   // 2048-bit state, word i = bytes 8i..8i+7
    typedef word_t [16:0] keep_t;    // feed-forward copy of words 15..31
    typedef word_t [15:0] half_t;    // one 64-bit half of each cell, row*4+col
    typedef word_t [3:0]  quad_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PERM,
        ST_OUT
    } fsh_state_t;

    localparam logic [3:0]  LAST_POS     = 4'd14;   // last word position of a block
    localparam logic [4:0]  DOMAIN_WORD  = 5'd15;   // holds byte 120
    localparam logic [3:0]  LAST_DIGEST  = 4'd15;
    localparam word_t       PAD_WORD     = 64'h80;
    localparam int          KEEP_BASE    = 15;

    localparam logic [7:0] RC_TAB [24] = '{
        8'h24, 8'h3f, 8'h6a, 8'h88, 8'h85, 8'ha3, 8'h08, 8'hd3,
        8'h13, 8'h19, 8'h8a, 8'h2e, 8'h03, 8'h70, 8'h73, 8'h44,
        8'ha4, 8'h09, 8'h38, 8'h22, 8'h29, 8'h9f, 8'h31, 8'hd0
    };

    localparam logic [6:0] ROT_TAB [4][3] = '{
        '{7'd14, 7'd20, 7'd22},
        '{7'd13, 7'd68, 7'd91},
        '{7'd27, 7'd42, 7'd106},
        '{7'd32, 7'd48, 7'd80}
    };

    // Bitsliced four-input S-box across one row
    function automatic quad_t sbox4(quad_t v);
        word_t o0, o1, o2, o3;
        quad_t r;
        o3 = (v[3] & v[2]) ^ v[1];
        o1 = (v[2] | v[1]) ^ v[0];
        o0 = (o3 & v[0]) ^ v[3];
        o2 = (o1 & v[3]) ^ v[2];
        r  = {o3, o2, o1, o0};
        return r;
    endfunction

    // Row d ^= row s, all four cells
    function automatic half_t row_xor(half_t x, int d, int s);
        half_t y;
        y = x;
        for (int c = 0; c < 4; c++)
        begin
            y[d*4 + c] = x[d*4 + c] ^ x[s*4 + c];
        end
        return y;
    endfunction

    // Multiply a row by x in the cell ring
    function automatic half_t row_mul(half_t x, int r);
        half_t y;
        y = x;
        y[r*4 + 3] = x[r*4 + 2];
        y[r*4 + 2] = x[r*4 + 1];
        y[r*4 + 1] = x[r*4 + 3] ^ x[r*4];
        y[r*4]     = x[r*4 + 3];
        return y;
    endfunction

    function automatic logic [127:0] rotr128(logic [127:0] v, logic [6:0] n);
        logic [255:0] d;
        d = {v, v} >> n;
        return d[127:0];
    endfunction

    // One full round; rnd is the round number (below 24)
    function automatic state_t perm_round(state_t s, logic [4:0] rnd);
        half_t        lo;
        half_t        hi;
        quad_t        q;
        logic [127:0] c;
        state_t       o;
        for (int row = 0; row < 4; row++)
        begin
            for (int col = 0; col < 4; col++)
            begin
                lo[row*4 + col] = s[2*(col*4 + row)];
                hi[row*4 + col] = s[2*(col*4 + row) + 1];
            end
        end
        // S-box layer
        for (int row = 0; row < 4; row++)
        begin
            q = sbox4({lo[row*4 + 3], lo[row*4 + 2], lo[row*4 + 1], lo[row*4]});
            for (int col = 0; col < 4; col++)
            begin
                lo[row*4 + col] = q[col];
            end
            q = sbox4({hi[row*4 + 3], hi[row*4 + 2], hi[row*4 + 1], hi[row*4]});
            for (int col = 0; col < 4; col++)
            begin
                hi[row*4 + col] = q[col];
            end
        end
        // Column mix
        lo = row_xor(lo, 2, 3); hi = row_xor(hi, 2, 3);
        lo = row_xor(lo, 0, 1); hi = row_xor(hi, 0, 1);
        lo = row_mul(lo, 1);    hi = row_mul(hi, 1);
        lo = row_mul(lo, 3);    hi = row_mul(hi, 3);
        lo = row_xor(lo, 1, 2); hi = row_xor(hi, 1, 2);
        lo = row_xor(lo, 3, 0); hi = row_xor(hi, 3, 0);
        lo = row_mul(lo, 0);    hi = row_mul(hi, 0);
        lo = row_mul(lo, 0);    hi = row_mul(hi, 0);
        lo = row_mul(lo, 2);    hi = row_mul(hi, 2);
        lo = row_mul(lo, 2);    hi = row_mul(hi, 2);
        lo = row_xor(lo, 2, 3); hi = row_xor(hi, 2, 3);
        lo = row_xor(lo, 0, 1); hi = row_xor(hi, 0, 1);
        lo = row_xor(lo, 1, 2); hi = row_xor(hi, 1, 2);
        lo = row_xor(lo, 3, 0); hi = row_xor(hi, 3, 0);
        // Row rotations, amounts picked by round mod 4
        for (int row = 1; row < 4; row++)
        begin
            for (int col = 0; col < 4; col++)
            begin
                c = rotr128({hi[row*4 + col], lo[row*4 + col]},
                            ROT_TAB[rnd[1:0]][row - 1]);
                lo[row*4 + col] = c[63:0];
                hi[row*4 + col] = c[127:64];
            end
        end
        // Round constant into cell (3,3)
        lo[15] = lo[15] ^ {56'd0, RC_TAB[rnd]};
        for (int row = 0; row < 4; row++)
        begin
            for (int col = 0; col < 4; col++)
            begin
                o[2*(col*4 + row)]     = lo[row*4 + col];
                o[2*(col*4 + row) + 1] = hi[row*4 + col];
            end
        end
        return o;
    endfunction

endpackage

>>> rtl/fsh_msg_if.sv
// fsh_msg_if: valid/ready channel carrying message words into the hash.
// No dependencies.
`timescale 1ns / 1ps

interface fsh_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [6:0]  valid_bits;
    logic        last_word;

    modport source (output valid, output message_word, output valid_bits,
                    output last_word, input ready);
    modport sink   (input valid, input message_word, input valid_bits,
                    input last_word, output ready);
endinterface

>>> rtl/fsh_dig_if.sv
// fsh_dig_if: valid/ready channel carrying digest words out of the hash.
// No dependencies.
`timescale 1ns / 1ps

interface fsh_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_last,
                    input ready);
    modport sink   (input valid, input digest_word, input digest_last,
                    output ready);
endinterface

>>> rtl/feedforward_sponge_hash_2048.sv
// feedforward_sponge_hash_2048: top level of the 2048-bit feed-forward sponge hash.
// Depends on fsh_pkg, fsh_msg_if and fsh_dig_if.
//
//   channel   | dir | payload                                    | per message
//   ----------+-----+--------------------------------------------+----------------
//   message   | in  | message_word[63:0] valid_bits[6:0] last_word | any number
//   digest    | out | digest_word[63:0] digest_last              | 16 transfers
//
// Message words are taken back to back while the input is open; every 15th
// word starts a permutation, one round per cycle through the shared round
// unit, during which no word is taken. The last word also starts a permutation,
// and a second one when its padding spills into a fresh block, then 16 digest
// transfers, one per cycle at best. A stalled digest holds its word; the input
// stays closed until the sixteenth transfer. Reset clears the state to zero.
`timescale 1ns / 1ps

module feedforward_sponge_hash_2048 #(
    parameter int ROUNDS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    fsh_msg_if.sink       message,
    fsh_dig_if.source     digest
);

    localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    fsh_pkg::fsh_state_t state_reg, state_next;
    fsh_pkg::state_t     sponge_reg, sponge_next;
    fsh_pkg::keep_t      keep_reg, keep_next;
    logic [RW-1:0]       round_reg, round_next;
    logic [3:0]          pos_reg, pos_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                fin_reg, fin_next;
    logic                pad_reg, pad_next;

    fsh_pkg::state_t     round_out;
    fsh_pkg::state_t     ff_vec;
    fsh_pkg::state_t     absorb_vec;
    fsh_pkg::keep_t      keep_src;
    logic [4:0]          rnd5;
    logic                last_round;
    logic                full_word;
    logic [2:0]          fb;
    logic [2:0]          eb;
    logic [63:0]         keep_mask;
    logic [7:0]          byte_sel;
    logic [7:0]          hi_mask;
    logic [7:0]          pad_byte;
    logic [63:0]         padded;

    // Shared round unit
    assign rnd5       = 5'(round_reg);
    assign round_out  = fsh_pkg::perm_round(sponge_reg, rnd5);
    assign last_round = (round_reg == RW'(ROUNDS - 1));

    // Feed-forward source: live state in round 0, saved copy afterwards
    always_comb
    begin
        keep_src = (round_reg == '0) ? sponge_reg[31:fsh_pkg::KEEP_BASE] : keep_reg;
        ff_vec   = '0;
        ff_vec[31:fsh_pkg::KEEP_BASE] = keep_src;
    end

    // Final-word padding: keep whole bytes, 1-then-zeros from bit e of the next
    assign full_word = !message.last_word || message.valid_bits[6];
    assign fb        = message.valid_bits[5:3];
    assign eb        = message.valid_bits[2:0];
    assign keep_mask = ~({64{1'b1}} << {fb, 3'b000});
    assign byte_sel  = 8'(message.message_word >> {fb, 3'b000});
    assign hi_mask   = 8'(8'hFF << (4'd8 - {1'b0, eb}));
    assign pad_byte  = (byte_sel & hi_mask) | 8'(8'h80 >> eb);
    assign padded    = (message.message_word & keep_mask) | (64'(pad_byte) << {fb, 3'b000});

    // Words XORed into the state on an input transfer
    always_comb
    begin
        absorb_vec = '0;
        absorb_vec[{1'b0, pos_reg}] = full_word ? message.message_word : padded;
        if (message.last_word && full_word && (pos_reg != fsh_pkg::LAST_POS))
        begin
            absorb_vec[{1'b0, 4'(pos_reg + 4'd1)}] = fsh_pkg::PAD_WORD;
        end
        if (message.last_word && !(full_word && (pos_reg == fsh_pkg::LAST_POS)))
        begin
            absorb_vec[fsh_pkg::DOMAIN_WORD] = absorb_vec[fsh_pkg::DOMAIN_WORD]
                                               ^ fsh_pkg::PAD_WORD;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fsh_pkg::ST_IDLE;
            sponge_reg <= '0;
            round_reg  <= '0;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            pad_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sponge_reg <= sponge_next;
            round_reg  <= round_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            pad_reg    <= pad_next;
        end
    end

    // Feed-forward copy, payload only
    always_ff @(posedge clk)
    begin
        keep_reg <= keep_next;
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        sponge_next = sponge_reg;
        keep_next   = keep_reg;
        round_next  = round_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        pad_next    = pad_reg;
        message.ready      = 1'b0;
        digest.valid       = 1'b0;
        digest.digest_word = sponge_reg[{1'b1, cnt_reg}];
        digest.digest_last = (cnt_reg == fsh_pkg::LAST_DIGEST);

        case (state_reg)
            fsh_pkg::ST_IDLE:
            begin
                message.ready = 1'b1;
                if (message.valid)
                begin
                    sponge_next = sponge_reg ^ absorb_vec;
                    round_next  = '0;
                    if (message.last_word)
                    begin
                        state_next = fsh_pkg::ST_PERM;
                        fin_next   = 1'b1;
                        pad_next   = full_word && (pos_reg == fsh_pkg::LAST_POS);
                        pos_next   = '0;
                    end
                    else if (pos_reg == fsh_pkg::LAST_POS)
                    begin
                        state_next = fsh_pkg::ST_PERM;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = 4'(pos_reg + 4'd1);
                    end
                end
            end

            fsh_pkg::ST_PERM:
            begin
                if (round_reg == '0)
                begin
                    keep_next = sponge_reg[31:fsh_pkg::KEEP_BASE];
                end
                if (last_round)
                begin
                    sponge_next = round_out ^ ff_vec;
                    round_next  = '0;
                    if (pad_reg)
                    begin
                        // Padding spilled into a fresh block: pad and go again
                        sponge_next[0] = sponge_next[0] ^ fsh_pkg::PAD_WORD;
                        sponge_next[fsh_pkg::DOMAIN_WORD] =
                            sponge_next[fsh_pkg::DOMAIN_WORD] ^ fsh_pkg::PAD_WORD;
                        pad_next = 1'b0;
                    end
                    else if (fin_reg)
                    begin
                        state_next = fsh_pkg::ST_OUT;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = fsh_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    sponge_next = round_out;
                    round_next  = RW'(round_reg + 1'b1);
                end
            end

            fsh_pkg::ST_OUT:
            begin
                digest.valid = 1'b1;
                if (digest.ready)
                begin
                    if (cnt_reg == fsh_pkg::LAST_DIGEST)
                    begin
                        state_next  = fsh_pkg::ST_IDLE;
                        sponge_next = '0;
                        pos_next    = '0;
                        fin_next    = 1'b0;
                        cnt_next    = '0;
                    end
                    else
                    begin
                        cnt_next = 4'(cnt_reg + 4'd1);
                    end
                end
            end

            default:
            begin
                state_next = fsh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/fsh_checker.sv
// fsh_checker: port-level checks on the sponge hash top level, with its bind.
// Depends on feedforward_sponge_hash_2048 and its channel interfaces.
`timescale 1ns / 1ps

module fsh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_last,
    input logic [63:0] out_word
);

    // Never open for input while a digest is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input open while digest valid");

    // Final message word closes the input
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("input still open after final word");

    // Last digest transfer reopens the input
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
        else $error("input not reopened after digest");

    // First digest word of a run is never the last
    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !out_last)
        else $error("digest run started on last word");

    // A stalled digest word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_word)
                                       && $stable(out_last)))
        else $error("stalled digest word changed");

endmodule

bind feedforward_sponge_hash_2048 fsh_checker u_fsh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (message.valid),
    .in_ready  (message.ready),
    .in_last   (message.last_word),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .out_last  (digest.digest_last),
    .out_word  (digest.digest_word)
);
